@@ sv/rlwe_dec_pkg.sv @@
// ============================================================================
// rlwe_dec_pkg
// Shared constants, state types and inter-module records of the ring
// decryption core.
// ============================================================================
package rlwe_dec_pkg;

    // Store geometry and field widths.
    localparam int MAX_DEGREE = 1024;
    localparam int ADDR_W     = $clog2(MAX_DEGREE);
    localparam int DEG_W      = ADDR_W + 1;
    localparam int COEFF_W    = 32;
    localparam int KEY_W      = 2;
    localparam int ACC_W      = 48;
    localparam int CNT_W      = $clog2(ACC_W);

    // Register reset values.
    localparam logic [DEG_W-1:0]   DEGREE_RESET  = DEG_W'(MAX_DEGREE);
    localparam logic [COEFF_W-1:0] MODULUS_RESET = COEFF_W'(12289);

    // Configuration register indexes.
    localparam logic REG_DEGREE  = 1'b0;
    localparam logic REG_MODULUS = 1'b1;

    // Input word kinds.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Two-bit key codes.
    localparam logic [KEY_W-1:0] KEY_ZERO      = 2'b00;
    localparam logic [KEY_W-1:0] KEY_MINUS_TWO = 2'b10;

    // Walker sequencer states.
    typedef enum logic [2:0] {
        W_IDLE,
        W_C0,
        W_WALK,
        W_DRAIN,
        W_DONE
    } walk_state_t;

    // Remainder unit states.
    typedef enum logic [1:0] {
        R_IDLE,
        R_DIV,
        R_DONE
    } red_state_t;

    // Read request to the coefficient stores.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] coeff_addr;
        logic [ADDR_W-1:0] key_addr;
    } mem_rd_req_t;

    // Accumulated sum handed from the walker to the remainder unit.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] index;
        logic              error;
        logic [ACC_W-1:0]  acc;
    } red_req_t;

    // Finished coefficient from the remainder unit.
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  index;
        logic               error;
        logic [COEFF_W-1:0] value;
    } red_res_t;

endpackage

@@ sv/rlwe_decryption_core.sv @@
// ============================================================================
// rlwe_decryption_core
// Ring decryption: one coefficient of c0 + c1*s modulo X^N+1, reduced mod q.
// ============================================================================
// A load word writes c0, c1 and the key coefficient at one index. A read word
// for index k walks the stores, one coefficient pair per cycle through the
// single read port of each memory, then passes through the bit-serial
// remainder unit; no other word is taken meanwhile. The result sits in an
// output register, so the next word is taken while it waits. A read at or
// above the degree in use returns zero with the error flag after the
// remainder pass. The stores are not cleared at reset and must be loaded
// before they are read.
// ============================================================================
module rlwe_decryption_core (
    input  logic        clk,
    input  logic        rst_n,
    // Input words.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // coeff_index, cipher0_coeff, cipher1_coeff, key_coeff
    input  logic        s_axis_tuser,   // cmd
    // Result words.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // result_index, plain_coeff
    output logic        m_axis_tuser,   // index_error
    // Configuration writes.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int AW = rlwe_dec_pkg::ADDR_W;
    localparam int DW = rlwe_dec_pkg::DEG_W;
    localparam int CW = rlwe_dec_pkg::COEFF_W;
    localparam int KW = rlwe_dec_pkg::KEY_W;

    logic [DW-1:0] degree_reg;
    logic [CW-1:0] modulus_reg;
    logic [DW-1:0] degree_eff;

    logic          in_accept;
    logic          in_load;
    logic          in_read;
    logic [AW-1:0] in_index;
    logic [CW-1:0] in_c0;
    logic [CW-1:0] in_c1;
    logic [KW-1:0] in_key;

    rlwe_dec_pkg::mem_rd_req_t rd_req;
    rlwe_dec_pkg::red_req_t    red_req;
    rlwe_dec_pkg::red_res_t    red_res;
    logic [CW-1:0] rd_c0;
    logic [CW-1:0] rd_c1;
    logic [KW-1:0] rd_key;
    logic          walk_busy;
    logic          red_ready;
    logic          res_take;

    logic          out_valid_reg;
    logic [AW-1:0] out_index_reg;
    logic [CW-1:0] out_value_reg;
    logic          out_err_reg;

    // Input word fields.
    assign in_index = s_axis_tdata[AW-1:0];
    assign in_c0    = s_axis_tdata[AW+CW-1:AW];
    assign in_c1    = s_axis_tdata[AW+2*CW-1:AW+CW];
    assign in_key   = s_axis_tdata[AW+2*CW+KW-1:AW+2*CW];

    // A word is taken only when the walker and the remainder unit are free.
    assign s_axis_tready = !walk_busy && red_ready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_load       = in_accept && (s_axis_tuser == rlwe_dec_pkg::CMD_LOAD);
    assign in_read       = in_accept && (s_axis_tuser == rlwe_dec_pkg::CMD_READ);

    // Degree saturates to the store depth.
    assign degree_eff = (degree_reg > DW'(rlwe_dec_pkg::MAX_DEGREE))
                      ? DW'(rlwe_dec_pkg::MAX_DEGREE) : degree_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg  <= rlwe_dec_pkg::DEGREE_RESET;
            modulus_reg <= rlwe_dec_pkg::MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == rlwe_dec_pkg::REG_DEGREE)
            begin
                degree_reg <= cfg_wdata[DW-1:0];
            end
            if (cfg_index == rlwe_dec_pkg::REG_MODULUS)
            begin
                modulus_reg <= cfg_wdata[CW-1:0];
            end
        end
    end

    rlwe_dec_store u_store (
        .clk     (clk),
        .wr_en   (in_load),
        .wr_addr (in_index),
        .wr_c0   (in_c0),
        .wr_c1   (in_c1),
        .wr_key  (in_key),
        .rd_req  (rd_req),
        .rd_c0   (rd_c0),
        .rd_c1   (rd_c1),
        .rd_key  (rd_key)
    );

    rlwe_dec_walk u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_read),
        .start_index (in_index),
        .degree      (degree_eff),
        .rd_c0       (rd_c0),
        .rd_c1       (rd_c1),
        .rd_key      (rd_key),
        .red_ready   (red_ready),
        .rd_req      (rd_req),
        .red_req     (red_req),
        .busy        (walk_busy)
    );

    rlwe_dec_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (red_req),
        .modulus  (modulus_reg),
        .res_take (res_take),
        .ready    (red_ready),
        .res      (red_res)
    );

    // Output register: refilled when empty or when its word is taken.
    assign res_take = red_res.valid && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_index_reg <= red_res.index;
            out_value_reg <= red_res.value;
            out_err_reg   <= red_res.error;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(48 - AW - CW){1'b0}}, out_value_reg, out_index_reg};
    assign m_axis_tuser  = out_err_reg;

`ifndef NO_ASSERTIONS
    // A read word keeps the input closed for the cycles that follow.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_read |=> !s_axis_tready)
        else $error("input reopened right after a read word");

    // An out-of-range read always returns a zero coefficient.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (out_value_reg == '0))
        else $error("error result with a nonzero coefficient");

    // A finished sum handed over is taken by the remainder unit at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (red_req.valid && red_ready) |=> (!red_ready && !red_res.valid))
        else $error("remainder unit did not start on hand-over");

    // A result word is never overwritten while it waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(out_value_reg))
        else $error("pending result word changed");
`endif

endmodule

@@ sv/rlwe_dec_store.sv @@
// ============================================================================
// rlwe_dec_store
// Coefficient memories: one holds the c0 and c1 pair of each index, the
// other the two-bit key. One write port, registered read data.
// ============================================================================
module rlwe_dec_store (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [rlwe_dec_pkg::ADDR_W-1:0]     wr_addr,
    input  logic [rlwe_dec_pkg::COEFF_W-1:0]    wr_c0,
    input  logic [rlwe_dec_pkg::COEFF_W-1:0]    wr_c1,
    input  logic [rlwe_dec_pkg::KEY_W-1:0]      wr_key,
    input  rlwe_dec_pkg::mem_rd_req_t           rd_req,
    output logic [rlwe_dec_pkg::COEFF_W-1:0]    rd_c0,
    output logic [rlwe_dec_pkg::COEFF_W-1:0]    rd_c1,
    output logic [rlwe_dec_pkg::KEY_W-1:0]      rd_key
);

    logic [2*rlwe_dec_pkg::COEFF_W-1:0] coeff_mem [rlwe_dec_pkg::MAX_DEGREE];
    logic [rlwe_dec_pkg::KEY_W-1:0]     key_mem   [rlwe_dec_pkg::MAX_DEGREE];
    logic [2*rlwe_dec_pkg::COEFF_W-1:0] coeff_rd_reg;
    logic [rlwe_dec_pkg::KEY_W-1:0]     key_rd_reg;

    // Pair memory: c1 in the upper half, c0 in the lower half.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            coeff_mem[wr_addr] <= {wr_c1, wr_c0};
        end
        if (rd_req.en)
        begin
            coeff_rd_reg <= coeff_mem[rd_req.coeff_addr];
        end
    end

    // Key memory, read at its own address.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (rd_req.en)
        begin
            key_rd_reg <= key_mem[rd_req.key_addr];
        end
    end

    assign rd_c0  = coeff_rd_reg[rlwe_dec_pkg::COEFF_W-1:0];
    assign rd_c1  = coeff_rd_reg[2*rlwe_dec_pkg::COEFF_W-1:rlwe_dec_pkg::COEFF_W];
    assign rd_key = key_rd_reg;

endmodule

@@ sv/rlwe_dec_walk.sv @@
// ============================================================================
// rlwe_dec_walk
// Sequencer that walks the stores for one output coefficient and forms the
// exact signed sum c0[k] + sum of +-c1[i]*s[k-i mod N].
// ============================================================================
module rlwe_dec_walk (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [rlwe_dec_pkg::ADDR_W-1:0]     start_index,
    input  logic [rlwe_dec_pkg::DEG_W-1:0]      degree,
    input  logic [rlwe_dec_pkg::COEFF_W-1:0]    rd_c0,
    input  logic [rlwe_dec_pkg::COEFF_W-1:0]    rd_c1,
    input  logic [rlwe_dec_pkg::KEY_W-1:0]      rd_key,
    input  logic                                red_ready,
    output rlwe_dec_pkg::mem_rd_req_t           rd_req,
    output rlwe_dec_pkg::red_req_t              red_req,
    output logic                                busy
);

    localparam int AW = rlwe_dec_pkg::ADDR_W;
    localparam int DW = rlwe_dec_pkg::DEG_W;
    localparam int XW = rlwe_dec_pkg::ACC_W - rlwe_dec_pkg::COEFF_W;

    rlwe_dec_pkg::walk_state_t state_reg, state_next;

    logic [AW-1:0]                  i_reg, i_next;
    logic [AW-1:0]                  kidx_reg, kidx_next;
    logic                           wrap_reg, wrap_next;
    logic [AW-1:0]                  k_reg, k_next;
    logic                           err_reg, err_next;
    logic [rlwe_dec_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic                           pend_c0_reg, pend_term_reg, pend_neg_reg;

    logic [DW-1:0]                  last_i;
    logic                           in_range;
    logic [rlwe_dec_pkg::ACC_W-1:0] term_mag;
    logic                           term_sub;

    assign last_i   = degree - DW'(1);
    assign in_range = {1'b0, start_index} < degree;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rlwe_dec_pkg::W_IDLE:
            begin
                if (start)
                begin
                    state_next = in_range ? rlwe_dec_pkg::W_C0 : rlwe_dec_pkg::W_DONE;
                end
            end
            rlwe_dec_pkg::W_C0:
            begin
                state_next = rlwe_dec_pkg::W_WALK;
            end
            rlwe_dec_pkg::W_WALK:
            begin
                if ({1'b0, i_reg} == last_i)
                begin
                    state_next = rlwe_dec_pkg::W_DRAIN;
                end
            end
            rlwe_dec_pkg::W_DRAIN:
            begin
                state_next = rlwe_dec_pkg::W_DONE;
            end
            rlwe_dec_pkg::W_DONE:
            begin
                if (red_ready)
                begin
                    state_next = rlwe_dec_pkg::W_IDLE;
                end
            end
            default:
            begin
                state_next = rlwe_dec_pkg::W_IDLE;
            end
        endcase
    end

    // Outputs: memory addresses and the hand-over to the remainder unit.
    always_comb
    begin
        rd_req.en         = 1'b0;
        rd_req.coeff_addr = i_reg;
        rd_req.key_addr   = kidx_reg;
        red_req.valid     = 1'b0;
        red_req.index     = k_reg;
        red_req.error     = err_reg;
        red_req.acc       = acc_reg;
        busy              = 1'b1;
        case (state_reg)
            rlwe_dec_pkg::W_IDLE:
            begin
                busy = 1'b0;
            end
            rlwe_dec_pkg::W_C0:
            begin
                rd_req.en         = 1'b1;
                rd_req.coeff_addr = k_reg;
            end
            rlwe_dec_pkg::W_WALK:
            begin
                rd_req.en = 1'b1;
            end
            rlwe_dec_pkg::W_DONE:
            begin
                red_req.valid = 1'b1;
            end
            default:
            begin
                rd_req.en = 1'b0;
            end
        endcase
    end

    // Key product: zero, one or two times c1, with its sign.
    always_comb
    begin
        term_mag = {{XW{1'b0}}, rd_c1};
        if (rd_key == rlwe_dec_pkg::KEY_MINUS_TWO)
        begin
            term_mag = {term_mag[rlwe_dec_pkg::ACC_W-2:0], 1'b0};
        end
        if (rd_key == rlwe_dec_pkg::KEY_ZERO)
        begin
            term_mag = '0;
        end
        term_sub = rd_key[1] ^ pend_neg_reg;
    end

    // Index walk and accumulation.
    always_comb
    begin
        i_next    = i_reg;
        kidx_next = kidx_reg;
        wrap_next = wrap_reg;
        k_next    = k_reg;
        err_next  = err_reg;
        acc_next  = acc_reg;
        if (state_reg == rlwe_dec_pkg::W_IDLE && start)
        begin
            k_next   = start_index;
            err_next = !in_range;
            acc_next = '0;
        end
        if (state_reg == rlwe_dec_pkg::W_C0)
        begin
            i_next    = '0;
            kidx_next = k_reg;
            wrap_next = 1'b0;
        end
        if (state_reg == rlwe_dec_pkg::W_WALK)
        begin
            i_next = i_reg + AW'(1);
            if (kidx_reg == '0)
            begin
                // Past index zero the key index wraps and terms change sign.
                kidx_next = last_i[AW-1:0];
                wrap_next = 1'b1;
            end
            else
            begin
                kidx_next = kidx_reg - AW'(1);
            end
        end
        if (pend_c0_reg)
        begin
            acc_next = acc_reg + {{XW{1'b0}}, rd_c0};
        end
        else if (pend_term_reg)
        begin
            acc_next = term_sub ? acc_reg - term_mag : acc_reg + term_mag;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rlwe_dec_pkg::W_IDLE;
            pend_c0_reg   <= 1'b0;
            pend_term_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_c0_reg   <= (state_reg == rlwe_dec_pkg::W_C0);
            pend_term_reg <= (state_reg == rlwe_dec_pkg::W_WALK);
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        kidx_reg     <= kidx_next;
        wrap_reg     <= wrap_next;
        k_reg        <= k_next;
        err_reg      <= err_next;
        acc_reg      <= acc_next;
        pend_neg_reg <= wrap_reg;
    end

endmodule

@@ sv/rlwe_dec_reduce.sv @@
// ============================================================================
// rlwe_dec_reduce
// Bit-serial remainder unit: reduces the signed sum into [0, q), one bit of
// the magnitude per cycle. A modulus of zero stands for 2^32.
// ============================================================================
module rlwe_dec_reduce (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rlwe_dec_pkg::red_req_t              req,
    input  logic [rlwe_dec_pkg::COEFF_W-1:0]    modulus,
    input  logic                                res_take,
    output logic                                ready,
    output rlwe_dec_pkg::red_res_t              res
);

    localparam int AW = rlwe_dec_pkg::ACC_W;
    localparam int CW = rlwe_dec_pkg::COEFF_W;
    localparam int NW = rlwe_dec_pkg::CNT_W;

    rlwe_dec_pkg::red_state_t state_reg, state_next;

    logic [AW-1:0]               mag_reg, mag_next;
    logic [CW:0]                 rem_reg, rem_next;
    logic [NW-1:0]               cnt_reg, cnt_next;
    logic                        neg_reg, neg_next;
    logic [CW-1:0]               lo_reg, lo_next;
    logic [rlwe_dec_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic                        err_reg, err_next;

    logic [CW:0]                 rem_sh;
    logic [CW:0]                 q_ext;
    logic                        last_step;

    assign q_ext     = {1'b0, modulus};
    assign rem_sh    = {rem_reg[CW-1:0], mag_reg[AW-1]};
    assign last_step = (cnt_reg == NW'(AW - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rlwe_dec_pkg::R_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = rlwe_dec_pkg::R_DIV;
                end
            end
            rlwe_dec_pkg::R_DIV:
            begin
                if (last_step)
                begin
                    state_next = rlwe_dec_pkg::R_DONE;
                end
            end
            rlwe_dec_pkg::R_DONE:
            begin
                if (res_take)
                begin
                    state_next = rlwe_dec_pkg::R_IDLE;
                end
            end
            default:
            begin
                state_next = rlwe_dec_pkg::R_IDLE;
            end
        endcase
    end

    // Outputs: the final fold of a negative sum happens on the way out.
    always_comb
    begin
        ready     = 1'b0;
        res.valid = 1'b0;
        res.index = idx_reg;
        res.error = err_reg;
        if (modulus == '0)
        begin
            res.value = lo_reg;
        end
        else if (neg_reg && rem_reg != '0)
        begin
            res.value = modulus - rem_reg[CW-1:0];
        end
        else
        begin
            res.value = rem_reg[CW-1:0];
        end
        case (state_reg)
            rlwe_dec_pkg::R_IDLE:
            begin
                ready = 1'b1;
            end
            rlwe_dec_pkg::R_DONE:
            begin
                res.valid = 1'b1;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

    // Restoring remainder step.
    always_comb
    begin
        mag_next = mag_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        lo_next  = lo_reg;
        idx_next = idx_reg;
        err_next = err_reg;
        if (state_reg == rlwe_dec_pkg::R_IDLE && req.valid)
        begin
            neg_next = req.acc[AW-1];
            mag_next = req.acc[AW-1] ? AW'(0) - req.acc : req.acc;
            lo_next  = req.acc[CW-1:0];
            rem_next = '0;
            cnt_next = '0;
            idx_next = req.index;
            err_next = req.error;
        end
        if (state_reg == rlwe_dec_pkg::R_DIV)
        begin
            mag_next = {mag_reg[AW-2:0], 1'b0};
            rem_next = (rem_sh >= q_ext) ? rem_sh - q_ext : rem_sh;
            cnt_next = cnt_reg + NW'(1);
        end
    end

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlwe_dec_pkg::R_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        lo_reg  <= lo_next;
        idx_reg <= idx_next;
        err_reg <= err_next;
    end

endmodule

@@ tb/sv/rlwe_decryption_core_tb.sv @@
// ============================================================================
// rlwe_decryption_core_tb
// Self-checking testbench for the ring decryption core.
// ============================================================================
// Load words fill the c0, c1 and key stores, and read words ask for one
// coefficient of c0 + c1*s modulo X^N+1, reduced modulo q. An in-bench copy of
// the stores computes each coefficient as an exact sum before reducing it, and
// every result word is checked field by field against the oldest expected
// coefficient. The run covers directed corner cases, randomised phases over
// many degree and modulus settings and a long receiver hold-off. Both sides
// of the stream idle at random.
// ============================================================================
module rlwe_decryption_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = rlwe_dec_pkg::ADDR_W;
    localparam int CW = rlwe_dec_pkg::COEFF_W;
    localparam int KW = rlwe_dec_pkg::KEY_W;
    localparam int DW = rlwe_dec_pkg::DEG_W;
    localparam int MAXD = rlwe_dec_pkg::MAX_DEGREE;

    // Key patterns not named in the package.
    localparam logic [KW-1:0] KEY_PLUS_ONE  = 2'b01;
    localparam logic [KW-1:0] KEY_MINUS_ONE = 2'b11;

    // Wait that lets a read at the largest degree finish, with some margin.
    localparam int SETTLE_CYCLES  = MAXD + 80;
    localparam int HOLD_CYCLES    = 3000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_WORDS    = 60;

    // Expected coefficient of one read.
    typedef struct {
        bit [AW-1:0] index;
        bit [CW-1:0] value;
        bit          error;
    } plain_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // coeff_index, cipher0_coeff, cipher1_coeff, key_coeff
    logic        s_axis_tuser;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // result_index, plain_coeff
    logic        m_axis_tuser;   // index_error
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;

    // In-bench copy of the stores and the registers.
    bit [CW-1:0] c0_mem [MAXD];
    bit [CW-1:0] c1_mem [MAXD];
    int          key_mem [MAXD];
    bit          loaded [MAXD];
    bit [DW-1:0] degree_reg;
    bit [CW-1:0] modulus_reg;

    plain_word_t plain_q [$];
    plain_word_t want_word;

    int loads_sent;
    int reads_sent;
    int range_errors;
    int cfg_writes;
    int words_checked;
    int mismatch_count;
    int stall_cycles;

    // Flow control state of the two sides.
    bit sender_calm;
    int hold_token;
    int hold_seen;
    int hold_left;
    int rx_cycle;

    rlwe_decryption_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Number of coefficients actually in use; larger settings saturate.
    function automatic int unsigned active_degree();
        return (degree_reg > MAXD) ? MAXD : int'(degree_reg);
    endfunction

    // Exact negacyclic sum for coefficient k, then reduced into [0, q).
    function automatic bit [CW-1:0] decrypt_coeff(input int unsigned k);
        int unsigned n;
        int unsigned i;
        int unsigned j;
        longint      q;
        longint      sum;
        longint      term;
        n   = active_degree();
        q   = (modulus_reg == 0) ? 64'sd4294967296 : longint'(modulus_reg);
        sum = longint'(c0_mem[k]);
        for (i = 0; i < n; i++)
        begin
            j    = (i <= k) ? (k - i) : (n + k - i);
            term = longint'(c1_mem[i]) * longint'(key_mem[j]);
            if (i > k)
                sum -= term;
            else
                sum += term;
        end
        sum = sum % q;
        if (sum < 0)
            sum += q;
        return sum[CW-1:0];
    endfunction

    // Coefficient values biased towards the extremes.
    function automatic bit [CW-1:0] rand_coeff();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    // Offer one word, wait for it to be taken, then update the prediction.
    task automatic send_word(input logic cmd, input bit [AW-1:0] idx,
                             input bit [CW-1:0] c0, input bit [CW-1:0] c1,
                             input bit [KW-1:0] key);
        int unsigned gap;
        plain_word_t want;
        if (!sender_calm && $urandom_range(99) < 12)
        begin
            gap = $urandom_range(4, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0000, key, c1, c0, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (cmd == rlwe_dec_pkg::CMD_LOAD)
        begin
            c0_mem[idx]  = c0;
            c1_mem[idx]  = c1;
            key_mem[idx] = int'($signed(key));
            loaded[idx]  = 1'b1;
            loads_sent++;
        end
        else
        begin
            want.index = idx;
            if (idx >= active_degree())
            begin
                want.value = '0;
                want.error = 1'b1;
                range_errors++;
            end
            else
            begin
                want.value = decrypt_coeff(idx);
                want.error = 1'b0;
            end
            plain_q.push_back(want);
            reads_sent++;
        end
    endtask

    task automatic load_coeff(input bit [AW-1:0] idx, input bit [CW-1:0] c0,
                              input bit [CW-1:0] c1, input bit [KW-1:0] key);
        send_word(rlwe_dec_pkg::CMD_LOAD, idx, c0, c1, key);
    endtask

    // The load fields of a read word are don't-care, so they carry noise.
    task automatic read_coeff(input bit [AW-1:0] idx);
        send_word(rlwe_dec_pkg::CMD_READ, idx, $urandom, $urandom, KW'($urandom));
    endtask

    // Register writes happen only once the core has drained and gone idle.
    task automatic write_register(input logic reg_sel, input bit [31:0] value);
        s_axis_tvalid <= 1'b0;
        while (plain_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= reg_sel;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (reg_sel == rlwe_dec_pkg::REG_DEGREE)
            degree_reg = value[DW-1:0];
        else
            modulus_reg = value;
        cfg_writes++;
    endtask

    // Every entry below the degree in use must hold data before any read.
    task automatic fill_stores(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            if (!loaded[i])
                load_coeff(AW'(i), rand_coeff(), rand_coeff(), KW'($urandom));
    endtask

    // Hand-picked words: extreme values, every key pattern, range errors,
    // a zero modulus, the largest and smallest moduli and a zero degree.
    task automatic test_directed();
        write_register(rlwe_dec_pkg::REG_DEGREE, 4);
        write_register(rlwe_dec_pkg::REG_MODULUS, 0);
        load_coeff(0, '1, '1, KEY_PLUS_ONE);
        load_coeff(1, '0, '1, rlwe_dec_pkg::KEY_MINUS_TWO);
        load_coeff(2, 32'd12345, 32'h8000_0000, KEY_MINUS_ONE);
        load_coeff(3, '1, '0, rlwe_dec_pkg::KEY_ZERO);
        read_coeff(0);
        read_coeff(1);
        read_coeff(2);
        read_coeff(3);
        read_coeff(1023);
        read_coeff(4);
        write_register(rlwe_dec_pkg::REG_MODULUS, 32'hFFFF_FFFF);
        read_coeff(0);
        read_coeff(3);
        write_register(rlwe_dec_pkg::REG_MODULUS, 1);
        read_coeff(1);
        write_register(rlwe_dec_pkg::REG_DEGREE, 0);
        read_coeff(0);
        read_coeff(1023);
    endtask

    // Random phases, each with its own degree and modulus. Most words are
    // loads and in-range reads; some loads land beyond the degree in use and
    // some reads ask for an index out of range.
    task automatic test_random_phases();
        int unsigned phase;
        int unsigned n;
        int unsigned count;
        bit [31:0]   q;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       n = 1;
                1:       n = 2;
                default: n = $urandom_range(64, 3);
            endcase
            case (phase)
                0:       q = 1;
                1:       q = 0;
                2:       q = 32'hFFFF_FFFF;
                3:       q = 12289;
                4:       q = 2;
                default: q = $urandom;
            endcase
            write_register(rlwe_dec_pkg::REG_DEGREE, n);
            write_register(rlwe_dec_pkg::REG_MODULUS, q);
            sender_calm = (phase == 4 || phase == 5);
            fill_stores(n);
            count = 0;
            while (count < PHASE_WORDS)
            begin
                if ($urandom_range(99) < 45)
                begin
                    if ($urandom_range(3) == 0)
                        load_coeff(AW'($urandom_range(1023)), rand_coeff(), rand_coeff(),
                                   KW'($urandom));
                    else
                        load_coeff(AW'($urandom_range(n - 1)), rand_coeff(), rand_coeff(),
                                   KW'($urandom));
                end
                else if ($urandom_range(99) < 15)
                    read_coeff(AW'($urandom_range(1023, n)));
                else
                    read_coeff(AW'($urandom_range(n - 1)));
                count++;
            end
            sender_calm = 1'b0;
        end
    endtask

    // The receiver holds off for a long stretch while reads keep coming, so
    // the output register fills and the core stops taking words.
    task automatic test_backpressure();
        int i;
        write_register(rlwe_dec_pkg::REG_DEGREE, 32);
        write_register(rlwe_dec_pkg::REG_MODULUS, $urandom);
        fill_stores(32);
        hold_token <= hold_token + 1;
        for (i = 0; i < 6; i++)
            read_coeff(AW'($urandom_range(31)));
    endtask

    // Result side ready: random idling, a calm window and the long hold-off.
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_cycle >= 4000 && rx_cycle < 10000)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 12);
        rx_cycle++;
    end

    // Check each result word against the oldest expected coefficient.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (plain_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result word index %0d value %0d error %0b",
                             $realtime, m_axis_tdata[9:0], m_axis_tdata[41:10],
                             m_axis_tuser);
            end
            else
            begin
                want_word = plain_q.pop_front();
                words_checked++;
                if (m_axis_tdata[9:0] !== want_word.index
                    || m_axis_tdata[41:10] !== want_word.value
                    || m_axis_tuser !== want_word.error)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: expected index %0d value %0d error %0b, got %0d %0d %0b",
                                 $realtime, want_word.index, want_word.value,
                                 want_word.error, m_axis_tdata[9:0], m_axis_tdata[41:10],
                                 m_axis_tuser);
                end
            end
        end
    end

    // Watchdog on cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $realtime, stall_cycles, plain_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = 1'b0;
        cfg_wdata     = '0;
        degree_reg    = rlwe_dec_pkg::DEGREE_RESET;
        modulus_reg   = rlwe_dec_pkg::MODULUS_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phases();
        test_backpressure();

        s_axis_tvalid <= 1'b0;
        while (plain_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d loads and %0d reads (%0d out of range) across %0d register writes.",
                 loads_sent, reads_sent, range_errors, cfg_writes);
        $display("Checked %0d result words; %0d mismatches, %0d still outstanding.",
                 words_checked, mismatch_count, plain_q.size());
        if (mismatch_count == 0 && plain_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
sv/rlwe_dec_pkg.sv
sv/rlwe_dec_store.sv
sv/rlwe_dec_walk.sv
sv/rlwe_dec_reduce.sv
sv/rlwe_decryption_core.sv
tb/sv/rlwe_decryption_core_tb.sv
